// ===== src/bnr_pkg.sv =====
// Shared constants and types for the batch normalization and ReLU block.
package bnr_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int COUNT_W = 7;
  localparam int DATA_WIDTH = 16;
  localparam int RESULT_W = 15;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [RESULT_W-1:0] RESULT_MAX = RESULT_W'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_CHANNELS);
  localparam logic [31:0] SCALE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SCALE_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = CFG_IDX_W'(0),
    REG_EPSILON       = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] gamma;
    logic [15:0] beta;
    logic [15:0] mean;
    logic [15:0] variance;
    logic [15:0] epsilon;
  } load_req_t;

  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] shift;
  } coef_t;

endpackage

// ===== src/bnr_in_if.sv =====
// Input request channel carrying parameter loads and activation samples.
interface bnr_in_if;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [bnr_pkg::CH_W-1:0] param_channel;
  logic signed [15:0]      gamma;
  logic signed [15:0]      beta;
  logic signed [15:0]      mean;
  logic [15:0]             variance;
  logic signed [15:0]      sample;
  logic                    last_sample;

  modport source (
    output valid, opcode, param_channel, gamma, beta, mean, variance, sample, last_sample,
    input  ready
  );
  modport sink (
    input  valid, opcode, param_channel, gamma, beta, mean, variance, sample, last_sample,
    output ready
  );
endinterface

// ===== src/bnr_out_if.sv =====
// Output request channel carrying normalized activations.
interface bnr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bnr_pkg::RESULT_W-1:0] result;
  logic [bnr_pkg::CH_W-1:0]     result_channel;
  logic                         misaligned;

  modport source (output valid, result, result_channel, misaligned, input ready);
  modport sink (input valid, result, result_channel, misaligned, output ready);
endinterface

// ===== src/bnr_cfg_if.sv =====
// Configuration write channel.
interface bnr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bnr_pkg::CFG_IDX_W-1:0]  index;
  logic [bnr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bnr_param_unit.sv =====
// Sequential unit that turns one channel's parameters into scale and shift.
module bnr_param_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bnr_pkg::load_req_t req,
  output logic               done,
  output bnr_pkg::coef_t     coef
);

  typedef enum logic [2:0] {IDLE, SQRT, DIV, SCL, MUL, FIN} state_t;

  state_t             state;
  bnr_pkg::load_req_t req_q;
  logic [41:0]        rem;
  logic [41:0]        root;
  logic [41:0]        bitv;
  logic [20:0]        divisor;
  logic [20:0]        drem;
  logic [39:0]        quo;
  logic [5:0]         cnt;
  logic signed [31:0] scale;
  logic signed [47:0] prod;

  logic [24:0]        rad;
  logic [41:0]        trial;
  logic [41:0]        root_next;
  logic               g_neg;
  logic [15:0]        g_mag;
  logic [21:0]        remw;
  logic               ge;
  logic [20:0]        drem_next;
  logic [31:0]        scale_calc;
  logic signed [15:0] mean_s;
  logic signed [47:0] prod_sh;
  logic signed [40:0] diff;
  logic               fits;

  always_comb begin
    rad = {1'b0, req.variance, 8'h00} + {9'b0, req.epsilon};
    trial = root + bitv;
    root_next = (rem >= trial) ? ((root >> 1) + bitv) : (root >> 1);
    g_neg = req_q.gamma[15];
    g_mag = g_neg ? 16'(~req_q.gamma + 16'd1) : req_q.gamma;
    remw = {drem, quo[39]};
    ge = remw >= {1'b0, divisor};
    drem_next = ge ? 21'(remw - {1'b0, divisor}) : remw[20:0];
    if (root == 42'd0) begin
      if (req_q.gamma == 16'd0) begin
        scale_calc = 32'd0;
      end else begin
        scale_calc = g_neg ? bnr_pkg::SCALE_MIN : bnr_pkg::SCALE_MAX;
      end
    end else if (g_neg) begin
      scale_calc = (quo > 40'h00_8000_0000) ? bnr_pkg::SCALE_MIN : 32'(~quo[31:0] + 32'd1);
    end else begin
      scale_calc = (quo > 40'h00_7FFF_FFFF) ? bnr_pkg::SCALE_MAX : quo[31:0];
    end
    mean_s = req_q.mean;
    prod_sh = prod >>> 8;
    diff = $signed({{17{req_q.beta[15]}}, req_q.beta, 8'h00}) - $signed(prod_sh[40:0]);
    fits = (&diff[40:31]) | ~(|diff[40:31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == FIN);
      case (state)
        IDLE: begin
          if (start) begin
            req_q <= req;
            rem <= 42'(rad) << 16;
            root <= 42'd0;
            bitv <= 42'd1 << 40;
            state <= SQRT;
          end
        end
        SQRT: begin
          if (rem >= trial) begin
            rem <= rem - trial;
          end
          root <= root_next;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            divisor <= root_next[20:0];
            drem <= 21'd0;
            quo <= {g_mag, 24'h000000};
            cnt <= 6'd0;
            state <= (root_next == 42'd0) ? SCL : DIV;
          end
        end
        DIV: begin
          drem <= drem_next;
          quo <= {quo[38:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd39) begin
            state <= SCL;
          end
        end
        SCL: begin
          scale <= scale_calc;
          state <= MUL;
        end
        MUL: begin
          prod <= scale * mean_s;
          state <= FIN;
        end
        FIN: begin
          coef.scale <= scale;
          coef.shift <= fits ? diff[31:0] : (diff[40] ? bnr_pkg::SCALE_MIN : bnr_pkg::SCALE_MAX);
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/batchnorm_relu_inference.sv =====
// Top level of the inference batch normalization and ReLU block.
// A parameter load runs a bit-serial square root and a restoring divider
// (skipped for a zero radicand) and then writes the channel's scale and shift
// into a 64-entry coefficient memory; the input stays not ready until the load
// is written. A sample reads its channel's coefficients from that memory when
// accepted, then multiplies and adds; the input takes no new request until the
// sample's result is in the result register. One result register parts the
// output from the input, so a waiting result does not stop the next sample
// from being read and multiplied. Channel count and epsilon are written
// through the configuration channel, which is ready whenever reset is low.
module batchnorm_relu_inference (
  input logic   clk,
  input logic   rst,
  bnr_in_if.sink    in_ch,
  bnr_out_if.source out_ch,
  bnr_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {IDLE, LOAD, MULT, FINISH} state_t;

  state_t                          state;
  logic [bnr_pkg::COUNT_W-1:0]     channel_count;
  logic [15:0]                     epsilon;
  logic [bnr_pkg::CH_W-1:0]        position;
  logic [bnr_pkg::CH_W-1:0]        load_ch;
  logic [bnr_pkg::CH_W-1:0]        cur_ch;
  logic                            cur_mis;
  logic signed [15:0]              cur_x;
  bnr_pkg::coef_t                  rd_data;
  bnr_pkg::coef_t                  mem [bnr_pkg::MAX_CHANNELS];
  logic signed [47:0]              sprod;
  logic                            out_valid;
  logic [bnr_pkg::RESULT_W-1:0]    out_result;
  logic [bnr_pkg::CH_W-1:0]        out_channel;
  logic                            out_mis;

  logic                            in_acc;
  logic                            pu_start;
  bnr_pkg::load_req_t              pu_req;
  logic                            pu_done;
  bnr_pkg::coef_t                  pu_coef;
  logic [bnr_pkg::COUNT_W-1:0]     eff_count;
  logic [bnr_pkg::CH_W-1:0]        ch_sel;
  logic                            closes;
  logic signed [31:0]              scale_s;
  logic signed [47:0]              sprod_sh;
  logic signed [40:0]              y;
  logic [bnr_pkg::RESULT_W-1:0]    res_calc;

  assign in_ch.ready = (state == IDLE) && !rst;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg.ready = !rst;
  assign out_ch.valid = out_valid;
  assign out_ch.result = out_result;
  assign out_ch.result_channel = out_channel;
  assign out_ch.misaligned = out_mis;

  assign pu_start = in_acc && (in_ch.opcode == bnr_pkg::OP_LOAD);
  assign pu_req = '{gamma: in_ch.gamma, beta: in_ch.beta, mean: in_ch.mean,
                    variance: in_ch.variance, epsilon: epsilon};

  bnr_param_unit u_param (
    .clk   (clk),
    .rst   (rst),
    .start (pu_start),
    .req   (pu_req),
    .done  (pu_done),
    .coef  (pu_coef)
  );

  always_comb begin
    if (channel_count == '0) begin
      eff_count = bnr_pkg::COUNT_W'(1);
    end else if (channel_count > bnr_pkg::COUNT_MAX) begin
      eff_count = bnr_pkg::COUNT_MAX;
    end else begin
      eff_count = channel_count;
    end
    ch_sel = ({1'b0, position} >= eff_count) ? '0 : position;
    closes = ({1'b0, ch_sel} + bnr_pkg::COUNT_W'(1)) == eff_count;
    scale_s = rd_data.scale;
    sprod_sh = sprod >>> 8;
    y = $signed(sprod_sh[40:0]) + $signed({{9{rd_data.shift[31]}}, rd_data.shift});
    if (y[40] || y == 41'sd0) begin
      res_calc = '0;
    end else if (y[40:8] > 33'(bnr_pkg::RESULT_MAX)) begin
      res_calc = bnr_pkg::RESULT_MAX;
    end else begin
      res_calc = y[8 +: bnr_pkg::RESULT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (pu_done && state == LOAD) begin
      mem[load_ch] <= pu_coef;
    end
    if (in_acc && in_ch.opcode == bnr_pkg::OP_SAMPLE) begin
      rd_data <= mem[ch_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      channel_count <= bnr_pkg::COUNT_W'(1);
      epsilon <= 16'd66;
      position <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          bnr_pkg::REG_CHANNEL_COUNT: channel_count <= cfg.data[bnr_pkg::COUNT_W-1:0];
          bnr_pkg::REG_EPSILON:       epsilon <= cfg.data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == bnr_pkg::OP_LOAD) begin
              load_ch <= in_ch.param_channel;
              state <= LOAD;
            end else begin
              cur_ch <= ch_sel;
              cur_x <= in_ch.sample;
              cur_mis <= in_ch.last_sample && !closes;
              position <= (in_ch.last_sample || closes) ? '0 : ch_sel + bnr_pkg::CH_W'(1);
              state <= MULT;
            end
          end
        end
        LOAD: begin
          if (pu_done) begin
            state <= IDLE;
          end
        end
        MULT: begin
          sprod <= scale_s * cur_x;
          state <= FINISH;
        end
        FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_result <= res_calc;
            out_channel <= cur_ch;
            out_mis <= cur_mis;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== dv/batchnorm_relu_inference_tb.sv =====
// Self-checking testbench for the batch normalization and ReLU block with a predicting scoreboard.
module batchnorm_relu_inference_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LOAD_SETTLE = 100;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    bnr_pkg::op_t                opcode;
    logic [bnr_pkg::CH_W-1:0]    param_channel;
    logic signed [15:0]          gamma;
    logic signed [15:0]          beta;
    logic signed [15:0]          mean;
    logic [15:0]                 variance;
    logic signed [15:0]          sample;
    logic                        last_sample;
  } bn_request_t;

  typedef struct {
    logic [bnr_pkg::RESULT_W-1:0] result;
    logic [bnr_pkg::CH_W-1:0]     channel;
    logic                         misaligned;
  } activation_t;

  class activation_scoreboard;
    int scale_tbl[bnr_pkg::MAX_CHANNELS];
    int shift_tbl[bnr_pkg::MAX_CHANNELS];
    int position;
    logic [bnr_pkg::COUNT_W-1:0] count_reg;
    logic [15:0] eps_reg;
    activation_t pending_activations[$];
    int mismatches;
    int loads_seen;
    int samples_seen;
    int results_checked;
    int misaligned_seen;

    function new();
      position = 0;
      count_reg = 1;
      eps_reg = 66;
      mismatches = 0;
      loads_seen = 0;
      samples_seen = 0;
      results_checked = 0;
      misaligned_seen = 0;
    endfunction

    function void write_reg(logic [bnr_pkg::CFG_IDX_W-1:0] idx,
                            logic [bnr_pkg::CFG_DATA_W-1:0] value);
      if (idx == bnr_pkg::REG_CHANNEL_COUNT) begin
        count_reg = value[bnr_pkg::COUNT_W-1:0];
      end else if (idx == bnr_pkg::REG_EPSILON) begin
        eps_reg = value;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function longint clamp32(longint v);
      longint hi;
      longint lo;
      hi = longint'($signed(bnr_pkg::SCALE_MAX));
      lo = longint'($signed(bnr_pkg::SCALE_MIN));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function void derive_coefficients(bn_request_t req);
      longint g;
      longint b;
      longint mu;
      longint scale;
      longint mag;
      longint q;
      longint unsigned rad;
      longint unsigned root;
      g = longint'(req.gamma);
      b = longint'(req.beta);
      mu = longint'(req.mean);
      rad = longint'(req.variance) * 256 + longint'(eps_reg);
      root = int_sqrt(rad << 16);
      if (root == 0) begin
        if (g > 0) scale = longint'($signed(bnr_pkg::SCALE_MAX));
        else if (g < 0) scale = longint'($signed(bnr_pkg::SCALE_MIN));
        else scale = 0;
      end else begin
        mag = (g < 0 ? -g : g) <<< 24;
        q = mag / $signed(root);
        scale = clamp32(g < 0 ? -q : q);
      end
      scale_tbl[req.param_channel] = int'(scale);
      shift_tbl[req.param_channel] = int'(clamp32(b * 256 - ((scale * mu) >>> 8)));
    endfunction

    function void normalize_sample(bn_request_t req);
      int eff;
      longint x;
      longint y;
      longint q;
      activation_t predicted;
      if (count_reg == 0) eff = 1;
      else if (count_reg > bnr_pkg::COUNT_MAX) eff = bnr_pkg::MAX_CHANNELS;
      else eff = int'(count_reg);
      if (position >= eff) position = 0;
      x = longint'(req.sample);
      y = ((longint'(scale_tbl[position]) * x) >>> 8) + longint'(shift_tbl[position]);
      q = y >>> 8;
      if (y <= 0) predicted.result = '0;
      else if (q > longint'(bnr_pkg::RESULT_MAX)) predicted.result = bnr_pkg::RESULT_MAX;
      else predicted.result = bnr_pkg::RESULT_W'(q);
      predicted.channel = bnr_pkg::CH_W'(position);
      predicted.misaligned = req.last_sample && (position + 1 != eff);
      pending_activations.push_back(predicted);
      position = (req.last_sample || position + 1 == eff) ? 0 : position + 1;
    endfunction

    function void note_request(bn_request_t req);
      if (req.opcode == bnr_pkg::OP_LOAD) begin
        loads_seen++;
        derive_coefficients(req);
      end else begin
        samples_seen++;
        normalize_sample(req);
      end
    endfunction

    function void check_activation(logic [bnr_pkg::RESULT_W-1:0] result,
                                   logic [bnr_pkg::CH_W-1:0] channel, logic misaligned);
      activation_t want;
      if (pending_activations.size() == 0) begin
        $display("%0t: unexpected result %0d channel %0d misaligned %0d",
                 $time, result, channel, misaligned);
        mismatches++;
        return;
      end
      want = pending_activations.pop_front();
      results_checked++;
      if (misaligned === 1'b1) misaligned_seen++;
      if (result !== want.result) begin
        $display("%0t: result expected %0d got %0d", $time, want.result, result);
        mismatches++;
      end
      if (channel !== want.channel) begin
        $display("%0t: result_channel expected %0d got %0d", $time, want.channel, channel);
        mismatches++;
      end
      if (misaligned !== want.misaligned) begin
        $display("%0t: misaligned expected %0d got %0d", $time, want.misaligned, misaligned);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bnr_in_if  in_bus();
  bnr_out_if out_bus();
  bnr_cfg_if cfg_bus();

  batchnorm_relu_inference dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg    (cfg_bus)
  );

  activation_scoreboard sb = new();

  int rx_stall_mode = 0;
  int hold_off_requests = 0;
  int phases_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls on its own pattern and, on request, holds off for a long stretch.
  initial begin
    int hold_left;
    int hold_seen;
    int tick;
    hold_left = 0;
    hold_seen = 0;
    tick = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (out_bus.valid && out_bus.ready) begin
        sb.check_activation(out_bus.result, out_bus.result_channel, out_bus.misaligned);
      end
      if (hold_off_requests != hold_seen) begin
        hold_seen = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_stall_mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 1) == 1);
          2: out_bus.ready <= ((tick % 7) >= 3);
          default: out_bus.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("batchnorm_relu_inference test failed");
    $finish;
  end

  function automatic logic [15:0] rand16();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bn_request_t build_load(int ch, logic [15:0] g, logic [15:0] b,
                                             logic [15:0] m, logic [15:0] v);
    bn_request_t req;
    req.opcode = bnr_pkg::OP_LOAD;
    req.param_channel = bnr_pkg::CH_W'(ch);
    req.gamma = g;
    req.beta = b;
    req.mean = m;
    req.variance = v;
    req.sample = 16'($urandom);
    req.last_sample = 1'($urandom);
    return req;
  endfunction

  function automatic bn_request_t build_sample(logic [15:0] x, logic last);
    bn_request_t req;
    req.opcode = bnr_pkg::OP_SAMPLE;
    req.param_channel = bnr_pkg::CH_W'($urandom);
    req.gamma = 16'($urandom);
    req.beta = 16'($urandom);
    req.mean = 16'($urandom);
    req.variance = 16'($urandom);
    req.sample = x;
    req.last_sample = last;
    return req;
  endfunction

  function automatic int pick_tensor_len(int eff);
    if ($urandom_range(0, 4) != 0) return eff * $urandom_range(1, 3);
    return $urandom_range(1, 2 * eff);
  endfunction

  task automatic issue_request(input bn_request_t req);
    in_bus.valid <= 1'b1;
    in_bus.opcode <= req.opcode;
    in_bus.param_channel <= req.param_channel;
    in_bus.gamma <= req.gamma;
    in_bus.beta <= req.beta;
    in_bus.mean <= req.mean;
    in_bus.variance <= req.variance;
    in_bus.sample <= req.sample;
    in_bus.last_sample <= req.last_sample;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(req);
  endtask

  task automatic sender_gap(input int cycles);
    in_bus.valid <= 1'b0;
    in_bus.sample <= 16'($urandom);
    in_bus.opcode <= bnr_pkg::op_t'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_activations.size() != 0);
  endtask

  task automatic write_register(input logic [bnr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bnr_pkg::CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, value);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle_block();
    drain_results();
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(input int n_items, input int count_value,
                           input logic [15:0] eps_value, input int rx_mode, input bit gapless);
    bn_request_t req;
    int eff;
    int tensor_len;
    int in_tensor;
    int burst_left;
    int hold_at;
    int drain_at;
    settle_block();
    if ($urandom_range(0, 1) == 1) begin
      write_register(bnr_pkg::REG_CHANNEL_COUNT, {9'($urandom), 7'(count_value)});
    end else begin
      write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'(count_value));
    end
    write_register(bnr_pkg::REG_EPSILON, eps_value);
    if ($urandom_range(0, 2) == 0) begin
      write_register(bnr_pkg::CFG_IDX_W'($urandom_range(2, 15)), 16'($urandom));
    end
    rx_stall_mode = rx_mode;
    phases_run++;
    if (count_value == 0) eff = 1;
    else if (count_value > bnr_pkg::MAX_CHANNELS) eff = bnr_pkg::MAX_CHANNELS;
    else eff = count_value;
    tensor_len = pick_tensor_len(eff);
    in_tensor = 0;
    burst_left = $urandom_range(1, 24);
    hold_at = $urandom_range(n_items / 4, n_items / 2);
    drain_at = $urandom_range(n_items / 2 + 1, n_items - 1);
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_requests++;
      if (i == drain_at) drain_results();
      if ($urandom_range(0, 11) == 0) begin
        req = build_load($urandom_range(0, bnr_pkg::MAX_CHANNELS - 1), rand16(), rand16(),
                         rand16(), rand16());
      end else begin
        in_tensor++;
        req = build_sample(rand16(), in_tensor == tensor_len);
        if (in_tensor == tensor_len) begin
          in_tensor = 0;
          tensor_len = pick_tensor_len(eff);
        end
      end
      issue_request(req);
      if (!gapless) begin
        burst_left--;
        if (burst_left == 0) begin
          sender_gap($urandom_range(1, 12));
          burst_left = $urandom_range(1, 24);
        end
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_bus.valid <= 1'b0;
    in_bus.opcode <= bnr_pkg::OP_LOAD;
    in_bus.param_channel <= '0;
    in_bus.gamma <= '0;
    in_bus.beta <= '0;
    in_bus.mean <= '0;
    in_bus.variance <= '0;
    in_bus.sample <= '0;
    in_bus.last_sample <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one channel, default epsilon, extreme parameters and samples.
    rx_stall_mode = 3;
    issue_request(build_load(0, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000));
    issue_request(build_sample(16'h7FFF, 1'b0));
    issue_request(build_sample(16'h8000, 1'b1));
    issue_request(build_sample(16'h0000, 1'b0));
    issue_request(build_sample(16'h0001, 1'b1));
    issue_request(build_load(0, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF));
    issue_request(build_sample(16'h7FFF, 1'b1));
    issue_request(build_sample(16'h8000, 1'b0));

    // Zero radicand for positive, negative and zero gamma, then every channel loaded.
    settle_block();
    write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'(bnr_pkg::MAX_CHANNELS));
    write_register(bnr_pkg::REG_EPSILON, 16'h0000);
    issue_request(build_load(1, 16'h0005, 16'h0100, 16'h0040, 16'h0000));
    issue_request(build_load(2, 16'hFFFB, 16'h7FFF, 16'hFFC0, 16'h0000));
    issue_request(build_load(3, 16'h0000, 16'h0200, 16'h8000, 16'h0000));
    for (int ch = 0; ch < bnr_pkg::MAX_CHANNELS; ch++) begin
      if (ch < 1 || ch > 3) issue_request(build_load(ch, rand16(), rand16(), rand16(), rand16()));
    end
    for (int k = 0; k < 4; k++) issue_request(build_sample(rand16(), k == 3));

    // A written count of zero acts as one, and a count above the table acts as the maximum.
    settle_block();
    write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'h0000);
    issue_request(build_sample(rand16(), 1'b0));
    issue_request(build_sample(rand16(), 1'b1));
    settle_block();
    write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'd100);
    for (int k = 0; k < 3; k++) issue_request(build_sample(rand16(), 1'b0));

    // Shrinking the count under the current position wraps the next sample to channel zero.
    settle_block();
    write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'd8);
    for (int k = 0; k < 5; k++) issue_request(build_sample(rand16(), 1'b0));
    settle_block();
    write_register(bnr_pkg::REG_CHANNEL_COUNT, 16'd3);
    issue_request(build_sample(rand16(), 1'b0));
    issue_request(build_sample(rand16(), 1'b0));

    run_phase(150, 1, 16'd66, 0, 1'b1);
    run_phase(150, bnr_pkg::MAX_CHANNELS, 16'h0000, 1, 1'b0);
    run_phase(150, bnr_pkg::MAX_CHANNELS, 16'hFFFF, 2, 1'b0);
    run_phase(150, 7, 16'($urandom), 3, 1'b0);
    run_phase(150, $urandom_range(2, bnr_pkg::MAX_CHANNELS - 1), 16'($urandom), 1, 1'b0);
    run_phase(150, 0, 16'($urandom), 2, 1'b0);
    run_phase(150, 127, 16'h0001, 0, 1'b0);
    run_phase(150, 16, 16'($urandom), 3, 1'b1);

    drain_results();
    repeat (LOAD_SETTLE) @(posedge clk);

    $display("Sent %0d parameter loads and %0d samples across %0d register settings.",
             sb.loads_seen, sb.samples_seen, phases_run);
    $display("Checked %0d results, %0d of them flagged as misaligned tensor ends.",
             sb.results_checked, sb.misaligned_seen);
    if (sb.mismatches == 0 && sb.pending_activations.size() == 0) begin
      $display("batchnorm_relu_inference test passed");
    end else begin
      $display("batchnorm_relu_inference test failed");
    end
    $finish;
  end

endmodule
